/* rtl/kmgd_pkg.sv */
`default_nettype none

package kmgd_pkg;

  // fixed field widths
  localparam int unsigned ROW_W = 3;
  localparam int unsigned COL_W = 18;
  localparam int unsigned CFG_W = 8;

  // defaults for the top-level parameters
  localparam int unsigned ROWS_DEF = 8;
  localparam int unsigned COLS_DEF = 18;

  // debounce setting and counter value after reset
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 8'd5;

  typedef struct packed {
    logic [ROW_W-1:0] row_number;
    logic [COL_W-1:0] column_bits;
    logic             end_of_scan;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] stable_bits;
    logic             committed;
    logic             settling;
    logic             last_row;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic sample;      // take the accepted row into the candidate copy
    logic scan_end;    // counter update and possible commit
    logic load_first;  // load output register with row 0
    logic load_next;   // step readout index and load that row
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_idx;    // readout index sits on the final row
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/kmgd_datapath.sv */
`default_nettype none

module kmgd_datapath import kmgd_pkg::*; #(
  parameter int unsigned ROWS = ROWS_DEF,
  parameter int unsigned COLS = COLS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire in_item_t         in_data_i,
  input  wire dp_cmd_t          cmd_i,
  output dp_stat_t              stat_o,
  output out_item_t             out_data_o
);

  localparam int unsigned RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CW     = (COLS < COL_W) ? COLS : COL_W;

  logic [CW-1:0]     cand_q   [ROWS];
  logic [CW-1:0]     stable_q [ROWS];
  logic [CFG_W-1:0]  cfg_q;
  logic [CFG_W-1:0]  cnt_q, cnt_d;
  logic              changed_q;
  logic [RIDX_W-1:0] idx_q, idx_d;
  logic              commit_q, commit_d;
  logic              settling_q;
  out_item_t         out_q;

  logic [CW-1:0]     in_bits;
  logic [RIDX_W-1:0] in_idx;
  logic              in_hit;
  logic              in_diff;
  logic [CFG_W-1:0]  cnt_load;
  logic [CW-1:0]     rd_bits;

  assign in_bits = in_data_i.column_bits[CW-1:0];
  assign in_idx  = RIDX_W'(in_data_i.row_number);
  assign in_hit  = 32'(in_data_i.row_number) < ROWS;
  assign in_diff = in_hit && (cand_q[in_idx] != in_bits);

  // reload on change, then count down
  always_comb begin
    cnt_load = changed_q ? cfg_q : cnt_q;
    cnt_d    = cnt_load;
    commit_d = 1'b0;
    if (cnt_load != '0) begin
      cnt_d    = cnt_load - 1'b1;
      commit_d = (cnt_d == '0);
    end
  end

  assign idx_d   = cmd_i.load_next ? idx_q + 1'b1 : '0;
  assign rd_bits = stable_q[idx_d];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= DEBOUNCE_RESET;
      cnt_q      <= DEBOUNCE_RESET;
      changed_q  <= 1'b0;
      idx_q      <= '0;
      commit_q   <= 1'b0;
      settling_q <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        cand_q[r]   <= '0;
        stable_q[r] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      if (cmd_i.sample && in_diff) begin
        cand_q[in_idx] <= in_bits;
        changed_q      <= 1'b1;
      end
      if (cmd_i.scan_end) begin
        cnt_q      <= cnt_d;
        changed_q  <= 1'b0;
        commit_q   <= commit_d;
        settling_q <= (cnt_d != '0);
        if (commit_d) begin
          for (int r = 0; r < ROWS; r++) begin
            stable_q[r] <= cand_q[r];
          end
        end
      end
      if (cmd_i.load_first || cmd_i.load_next) begin
        idx_q <= idx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_first || cmd_i.load_next) begin
      out_q.out_row     <= ROW_W'(idx_d);
      out_q.stable_bits <= COL_W'(rd_bits);
      out_q.committed   <= commit_q;
      out_q.settling    <= settling_q;
      out_q.last_row    <= (idx_d == RIDX_W'(ROWS - 1));
    end
  end

  assign out_data_o      = out_q;
  assign stat_o.last_idx = (idx_q == RIDX_W'(ROWS - 1));

endmodule

`default_nettype wire

/* rtl/kmgd_ctrl.sv */
`default_nettype none

module kmgd_ctrl import kmgd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_eos_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ENDS = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_SHOW = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.sample = 1'b1;
          if (in_eos_i) begin
            state_d = ST_ENDS;
          end
        end
      end
      ST_ENDS: begin
        cmd_o.scan_end = 1'b1;
        state_d        = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load_first = 1'b1;
        state_d          = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (stat_i.last_idx) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.load_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/key_matrix_global_debounce_core.sv */
`default_nettype none

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   in_data_i   (in_item_t)
// out       output     out_valid_o / out_ready_i out_data_o  (out_item_t)
// cfg       input      cfg_we_i                  cfg_data_i  (debounce scans)
//
// a row beat that is not end of scan gives no result
// an end-of-scan beat runs a counter update and then the first load, then
// ROWS result beats, one per cycle while out_ready_i is high; the readout walk
// covers every stable row, from row 0 to the last
// no input beat is taken while the readout runs; a stalled result holds
// reset clears both matrix copies and sets setting and counter to five

module key_matrix_global_debounce_core import kmgd_pkg::*; #(
  parameter int unsigned ROWS = ROWS_DEF,
  parameter int unsigned COLS = COLS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // config
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  // row samples
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_item_t         in_data_i,
  // stable matrix readout
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_data_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: sample, scan end, readout
  kmgd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_eos_i    (in_data_i.end_of_scan),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // matrix copies, global counter and output register
  kmgd_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
